### rtl/tci_pkg.sv
// Package for the tempo curve interpolator.
// Holds the fixed field widths, the word field types and the command and status codes.
// Depends on nothing.
`default_nettype none
package tci_pkg;
	localparam int POS_W = 40;
	localparam int CMD_W = 2;
	localparam int STATUS_W = 3;
	localparam int HELD_W = 9;

	typedef logic [CMD_W-1:0] cmd_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [POS_W-1:0] pos_t;

	localparam cmd_t CMD_CLEAR = 2'd0;
	localparam cmd_t CMD_APPEND = 2'd1;
	localparam cmd_t CMD_QUERY = 2'd2;
	localparam cmd_t CMD_UNUSED = 2'd3;

	localparam status_t ST_OK = 3'd0;
	localparam status_t ST_EMPTY = 3'd1;
	localparam status_t ST_NOT_INCR = 3'd2;
	localparam status_t ST_TEMPO_ZERO = 3'd3;
	localparam status_t ST_FULL = 3'd4;
endpackage
`default_nettype wire

### rtl/tci_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none
module tci_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### rtl/tci_muldiv.sv
// Serial multiply-then-divide unit: q = (dx * mag) / span, truncated.
// Shift-add multiply, then restoring division one bit a cycle. Depends on tci_pkg.
`default_nettype none
module tci_muldiv #(
	parameter int TEMPO_W = 26
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  tci_pkg::pos_t      dx,
	input  logic [TEMPO_W-1:0] mag,
	input  tci_pkg::pos_t      span,
	output logic               done,
	output logic [TEMPO_W-1:0] q
);
	import tci_pkg::*;

	localparam int PW = POS_W + TEMPO_W;
	localparam int CNT_W = $clog2(PW + 1);
	localparam logic [1:0] P_IDLE = 2'd0;
	localparam logic [1:0] P_MUL = 2'd1;
	localparam logic [1:0] P_DIV = 2'd2;

	logic [1:0]         phase_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;
	logic [PW-1:0]      acc_q;
	logic [PW-1:0]      mcand_q;
	logic [TEMPO_W-1:0] mplier_q;
	logic [POS_W-1:0]   rem_q;
	logic [POS_W-1:0]   span_q;
	logic [POS_W:0]     rs;
	logic               ge;

	always_comb begin
		rs = {rem_q, acc_q[PW-1]};
		ge = rs >= {1'b0, span_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				P_IDLE: begin
					if (start) begin
						phase_q <= P_MUL;
						cnt_q <= CNT_W'(TEMPO_W);
					end
				end
				P_MUL: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						phase_q <= P_DIV;
						cnt_q <= CNT_W'(PW);
					end
				end
				P_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						phase_q <= P_IDLE;
						done_q <= 1'b1;
					end
				end
				default: begin
					phase_q <= P_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			P_IDLE: begin
				if (start) begin
					acc_q <= '0;
					mcand_q <= PW'(dx);
					mplier_q <= mag;
					span_q <= span;
					rem_q <= '0;
				end
			end
			P_MUL: begin
				if (mplier_q[0]) begin
					acc_q <= acc_q + mcand_q;
				end
				mcand_q <= {mcand_q[PW-2:0], 1'b0};
				mplier_q <= mplier_q >> 1;
			end
			P_DIV: begin
				if (ge) begin
					rem_q <= POS_W'(rs - {1'b0, span_q});
					acc_q <= {acc_q[PW-2:0], 1'b1};
				end else begin
					rem_q <= rs[POS_W-1:0];
					acc_q <= {acc_q[PW-2:0], 1'b0};
				end
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	assign done = done_q;
	assign q = acc_q[TEMPO_W-1:0];
endmodule
`default_nettype wire

### rtl/tempo_curve_interpolator.sv
// Tempo curve interpolator: a table of (sample offset, tempo) points in one RAM,
// queried by binary search and linear interpolation.
// Channels: input words carry command, position and tempo_in under in_valid/in_stall;
// result words carry tempo_out, status and points_held under out_valid/out_stall.
// Every input word gives exactly one result word, in order.
// A word is taken only while the sequencer is idle, one at a time.
// Clear and append go from acceptance through the execute and done states to
// the output register, as does a query clamped at the ends. An interior query
// makes binary search steps, each one RAM read state and one compare state
// (at most log2 of the table size steps), then runs the multiply and divide
// phases of the serial multiply-divide unit before the done state.
// The output register lets the next word be accepted while a result waits;
// a stalled result holds, and the sequencer waits at its end for the register.
// Reset empties the table (point count zero) and clears out_valid; the
// RAM contents are not cleared and need not be.
// Depends on tci_pkg, tci_ram and tci_muldiv.
`default_nettype none
module tempo_curve_interpolator #(
	parameter int MAX_POINTS = 256,
	parameter int TEMPO_FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  tci_pkg::cmd_t                command,
	input  tci_pkg::pos_t                position,
	input  logic [TEMPO_FRAC_BITS+9:0]   tempo_in,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [TEMPO_FRAC_BITS+9:0]   tempo_out,
	output tci_pkg::status_t             status,
	output logic [tci_pkg::HELD_W-1:0]   points_held
);
	import tci_pkg::*;

	localparam int TW = TEMPO_FRAC_BITS + 10;
	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int MW = POS_W + TW;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_SRCH = 3'd2;
	localparam logic [2:0] S_CMP = 3'd3;
	localparam logic [2:0] S_MD = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]    state_q;
	logic [CW-1:0] count_q;
	logic          out_valid_q;

	cmd_t          cmd_q;
	pos_t          pos_q;
	logic [TW-1:0] tin_q;
	pos_t          first_off_q;
	logic [TW-1:0] first_t_q;
	pos_t          last_off_q;
	logic [TW-1:0] last_t_q;
	logic [AW-1:0] lo_q;
	logic [AW-1:0] hi_q;
	pos_t          a_off_q;
	logic [TW-1:0] a_t_q;
	pos_t          b_off_q;
	logic [TW-1:0] b_t_q;
	logic [TW-1:0] res_tempo_q;
	status_t       res_status_q;
	logic [TW-1:0] tempo_out_q;
	status_t       status_q;
	logic [HELD_W-1:0] held_q;

	logic          full;
	logic          tzero;
	logic          noinc;
	logic          app_ok;
	logic [AW:0]   mid_sum;
	logic [AW-1:0] mid;
	logic          more;
	logic          out_free;
	logic          we;
	logic [MW-1:0] rdata;
	pos_t          rd_off;
	logic [TW-1:0] rd_t;
	logic          md_start;
	logic          md_done;
	logic [TW-1:0] md_q;
	pos_t          dx;
	pos_t          span;
	logic          up;
	logic [TW-1:0] mag;

	always_comb begin
		full = count_q >= CW'(MAX_POINTS);
		tzero = tin_q == '0;
		noinc = (count_q != '0) && (pos_q <= last_off_q);
		app_ok = !full && !tzero && !noinc;
		mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
		mid = mid_sum[AW:1];
		more = AW'(hi_q - lo_q) > AW'(1);
		out_free = !out_valid_q || !out_stall;
		we = (state_q == S_EXEC) && (cmd_q == CMD_APPEND) && app_ok;
		rd_off = rdata[MW-1:TW];
		rd_t = rdata[TW-1:0];
		md_start = (state_q == S_SRCH) && !more;
		dx = pos_q - a_off_q;
		span = b_off_q - a_off_q;
		up = b_t_q >= a_t_q;
		mag = up ? (b_t_q - a_t_q) : (a_t_q - b_t_q);
	end

	tci_ram #(
		.WIDTH(MW),
		.DEPTH(MAX_POINTS)
	) u_ram (
		.clk(clk),
		.we(we),
		.waddr(count_q[AW-1:0]),
		.wdata({pos_q, tin_q}),
		.raddr(mid),
		.rdata(rdata)
	);

	tci_muldiv #(
		.TEMPO_W(TW)
	) u_muldiv (
		.clk(clk),
		.arst_n(arst_n),
		.start(md_start),
		.dx(dx),
		.mag(mag),
		.span(span),
		.done(md_done),
		.q(md_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_DONE;
					if (cmd_q == CMD_CLEAR) begin
						count_q <= '0;
					end else if (cmd_q == CMD_APPEND) begin
						if (app_ok) begin
							count_q <= count_q + 1'b1;
						end
					end else if (cmd_q == CMD_QUERY) begin
						if (count_q != '0 && pos_q > first_off_q && pos_q < last_off_q) begin
							state_q <= S_SRCH;
						end
					end
				end
				S_SRCH: begin
					state_q <= more ? S_CMP : S_MD;
				end
				S_CMP: begin
					state_q <= S_SRCH;
				end
				S_MD: begin
					if (md_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q <= command;
				pos_q <= position;
				tin_q <= tempo_in;
			end
			S_EXEC: begin
				res_tempo_q <= '0;
				res_status_q <= ST_OK;
				lo_q <= '0;
				hi_q <= AW'(count_q - 1'b1);
				a_off_q <= first_off_q;
				a_t_q <= first_t_q;
				b_off_q <= last_off_q;
				b_t_q <= last_t_q;
				if (cmd_q == CMD_APPEND) begin
					if (full) begin
						res_status_q <= ST_FULL;
					end else if (tzero) begin
						res_status_q <= ST_TEMPO_ZERO;
					end else if (noinc) begin
						res_status_q <= ST_NOT_INCR;
					end else begin
						last_off_q <= pos_q;
						last_t_q <= tin_q;
						if (count_q == '0) begin
							first_off_q <= pos_q;
							first_t_q <= tin_q;
						end
					end
				end else if (cmd_q == CMD_QUERY) begin
					if (count_q == '0) begin
						res_status_q <= ST_EMPTY;
					end else if (pos_q <= first_off_q) begin
						res_tempo_q <= first_t_q;
					end else if (pos_q >= last_off_q) begin
						res_tempo_q <= last_t_q;
					end
				end
			end
			S_CMP: begin
				if (rd_off <= pos_q) begin
					lo_q <= mid;
					a_off_q <= rd_off;
					a_t_q <= rd_t;
				end else begin
					hi_q <= mid;
					b_off_q <= rd_off;
					b_t_q <= rd_t;
				end
			end
			S_MD: begin
				if (md_done) begin
					res_tempo_q <= up ? (a_t_q + md_q) : (a_t_q - md_q);
				end
			end
			S_DONE: begin
				if (out_free) begin
					tempo_out_q <= res_tempo_q;
					status_q <= res_status_q;
					held_q <= HELD_W'(count_q);
				end
			end
			default: begin
				cmd_q <= cmd_q;
			end
		endcase
	end

	assign in_stall = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign tempo_out = tempo_out_q;
	assign status = status_q;
	assign points_held = held_q;
endmodule
`default_nettype wire

### tb/tb_tempo_curve_interpolator.sv
// Testbench for the tempo curve interpolator: directed and random command words
// checked against an in-bench table model with binary search and interpolation.
// Depends on tci_pkg and tempo_curve_interpolator.
`timescale 1ns / 100ps
module tb_tempo_curve_interpolator;
	import tci_pkg::*;

	localparam int NPTS = 256;
	localparam int WATCHDOG = 20000;

	typedef struct packed {
		logic [25:0] tempo;
		status_t st;
		logic [8:0] held;
	} tempo_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	cmd_t command = CMD_CLEAR;
	pos_t position = '0;
	logic [25:0] tempo_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [25:0] tempo_out;
	status_t status;
	logic [8:0] points_held;

	logic [39:0] tbl_off [NPTS];
	logic [25:0] tbl_tempo [NPTS];
	int unsigned tbl_count = 0;
	tempo_result_t answers_due [$];
	int errors = 0;
	int quiet_cycles = 0;
	bit hold_off = 0;
	bit fast_phase = 0;

	tempo_curve_interpolator u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.command(command), .position(position), .tempo_in(tempo_in),
		.out_valid(out_valid), .out_stall(out_stall), .tempo_out(tempo_out),
		.status(status), .points_held(points_held)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [25:0] tempo_at(logic [39:0] pos);
		int unsigned lo, hi, mid;
		logic [39:0] dx, span;
		logic [25:0] a_t, b_t, mag;
		logic [127:0] prod;
		logic [127:0] q;
		lo = 0;
		hi = tbl_count - 1;
		if (pos <= tbl_off[0]) return tbl_tempo[0];
		if (pos >= tbl_off[hi]) return tbl_tempo[hi];
		while (hi - lo > 1) begin
			mid = lo + (hi - lo) / 2;
			if (tbl_off[mid] <= pos) lo = mid;
			else hi = mid;
		end
		a_t = tbl_tempo[lo];
		b_t = tbl_tempo[hi];
		dx = pos - tbl_off[lo];
		span = tbl_off[hi] - tbl_off[lo];
		mag = (b_t >= a_t) ? b_t - a_t : a_t - b_t;
		prod = 128'(dx) * 128'(mag);
		q = prod / 128'(span);
		return (b_t >= a_t) ? a_t + q[25:0] : a_t - q[25:0];
	endfunction

	function automatic tempo_result_t apply_word(cmd_t c, logic [39:0] p, logic [25:0] t);
		tempo_result_t r;
		r = '0;
		r.st = ST_OK;
		if (c == CMD_CLEAR) begin
			tbl_count = 0;
		end else if (c == CMD_APPEND) begin
			if (tbl_count >= NPTS) r.st = ST_FULL;
			else if (t == 0) r.st = ST_TEMPO_ZERO;
			else if (tbl_count > 0 && p <= tbl_off[tbl_count-1]) r.st = ST_NOT_INCR;
			else begin
				tbl_off[tbl_count] = p;
				tbl_tempo[tbl_count] = t;
				tbl_count++;
			end
		end else if (c == CMD_QUERY) begin
			if (tbl_count == 0) r.st = ST_EMPTY;
			else r.tempo = tempo_at(p);
		end
		r.held = tbl_count[8:0];
		return r;
	endfunction

	function automatic int gap_len();
		if (fast_phase) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
		return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
	endfunction

	task automatic send_word(cmd_t c, logic [39:0] p, logic [25:0] t);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		command <= c;
		position <= p;
		tempo_in <= t;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		answers_due.push_back(apply_word(c, p, t));
	endtask

	task automatic report_mismatch(string what, logic [39:0] got, logic [39:0] want);
		errors++;
		$display("mismatch %s: got %0d expected %0d", what, got, want);
	endtask

	always @(posedge clk) begin
		tempo_result_t want;
		if (out_valid && !out_stall) begin
			if (answers_due.size() == 0) begin
				report_mismatch("unexpected word", 40'd0, 40'd0);
			end else begin
				want = answers_due.pop_front();
				if (tempo_out !== want.tempo)
					report_mismatch("tempo_out", 40'(tempo_out), 40'(want.tempo));
				if (status !== want.st) report_mismatch("status", 40'(status), 40'(want.st));
				if (points_held !== want.held)
					report_mismatch("points_held", 40'(points_held), 40'(want.held));
			end
		end
	end

	always @(posedge clk) begin
		if (hold_off) out_stall <= 1'b1;
		else if (fast_phase) out_stall <= 1'b0;
		else out_stall <= ($urandom_range(0, 29) == 0) ? 1'b1 : ($urandom_range(0, 3) == 0);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG) begin
			$display("tb_tempo_curve_interpolator: FAIL");
			$finish;
		end
	end

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic fill_table(int n, logic [39:0] step_max);
		logic [39:0] p;
		p = 40'($urandom_range(0, 1000));
		send_word(CMD_CLEAR, 0, 0);
		for (int i = 0; i < n; i++) begin
			send_word(CMD_APPEND, p, 26'({$urandom, $urandom}) | 26'd1);
			p = 40'(p + 1 + ({$urandom, $urandom} % step_max));
		end
	endtask

	task automatic test_directed();
		send_word(CMD_QUERY, 40'hFF_FFFF_FFFF, 26'h3FF_FFFF);
		send_word(CMD_UNUSED, 40'h12345, 26'h1);
		send_word(CMD_APPEND, 40'd100, 26'd0);
		send_word(CMD_APPEND, 40'd0, 26'h3FF_FFFF);
		send_word(CMD_QUERY, 40'd0, 0);
		send_word(CMD_QUERY, 40'hFF_FFFF_FFFF, 0);
		send_word(CMD_APPEND, 40'd0, 26'd5);
		send_word(CMD_APPEND, 40'hFF_FFFF_FFFF, 26'd1);
		send_word(CMD_QUERY, 40'h80_0000_0000, 0);
		send_word(CMD_QUERY, 40'hFF_FFFF_FFFE, 0);
		send_word(CMD_APPEND, 40'hFF_FFFF_FFFF, 26'd7);
		send_word(CMD_CLEAR, 0, 0);
		send_word(CMD_APPEND, 40'd10, 26'd100);
		send_word(CMD_APPEND, 40'd20, 26'h3FF_FFFF);
		send_word(CMD_APPEND, 40'd30, 26'd1);
		send_word(CMD_QUERY, 40'd15, 0);
		send_word(CMD_QUERY, 40'd25, 0);
		send_word(CMD_QUERY, 40'd20, 0);
		send_word(CMD_QUERY, 40'd5, 0);
		send_word(CMD_UNUSED, 40'd0, 0);
		wait_drain();
	endtask

	task automatic test_full_table();
		fill_table(NPTS, 40'd1 << 30);
		send_word(CMD_APPEND, 40'hFF_FFFF_FFFF, 26'd0);
		send_word(CMD_APPEND, 40'hFF_FFFF_FFFF, 26'd9);
		for (int i = 0; i < 40; i++)
			send_word(CMD_QUERY,
				40'(tbl_off[0] + ({$urandom, $urandom} % (tbl_off[NPTS-1] + 2))), 0);
		wait_drain();
	endtask

	task automatic test_backpressure();
		fill_table(8, 40'd5000);
		hold_off = 1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 12; i++)
				send_word(CMD_QUERY, 40'($urandom_range(0, 40000)), 0);
		join
		wait_drain();
	endtask

	task automatic test_random();
		int n, sz;
		logic [39:0] hi_off;
		n = 0;
		while (n < 1200) begin
			sz = ($urandom_range(0, 9) == 0) ? $urandom_range(40, NPTS) : $urandom_range(1, 12);
			fill_table(sz, ($urandom_range(0, 1)) ? 40'd1000 : 40'd1 << 36);
			n += sz + 1;
			hi_off = tbl_off[tbl_count-1];
			for (int i = 0; i < 20; i++) begin
				case ($urandom_range(0, 15))
				0: send_word(CMD_APPEND, 40'({$urandom, $urandom}), 26'({$urandom, $urandom}));
				1: send_word(CMD_APPEND, hi_off, 26'($urandom_range(1, 50)));
				2: send_word(CMD_UNUSED, 40'({$urandom, $urandom}), 26'({$urandom, $urandom}));
				3: send_word(CMD_QUERY, 40'({$urandom, $urandom}), 26'({$urandom, $urandom}));
				default: send_word(CMD_QUERY, 40'({$urandom, $urandom} % (hi_off + 3)), 0);
				endcase
				n++;
			end
			if ($urandom_range(0, 7) == 0) begin
				wait_drain();
				fast_phase = !fast_phase;
			end
		end
		fast_phase = 0;
		wait_drain();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);
		test_directed();
		test_full_table();
		test_backpressure();
		test_random();
		if (errors == 0) $display("tb_tempo_curve_interpolator: PASS");
		else $display("tb_tempo_curve_interpolator: FAIL");
		$finish;
	end
endmodule
